>>> hdl/cshs_pkg.sv
package cshs_pkg;

    // counter and age width, at most the 32-bit result fields
    localparam int COUNTER_WIDTH = 32;
    localparam int PHASE_W       = 16;
    localparam int RESULT_W      = 32;
    localparam int HIST_BINS     = 4;

    typedef logic [COUNTER_WIDTH-1:0] t_cnt;
    typedef logic [$clog2(HIST_BINS)-1:0] t_bin;

    // operation codes
    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // sample tags, anything else counts as invalid
    localparam logic [1:0] TAG_PRIMARY   = 2'd0;
    localparam logic [1:0] TAG_ALTERNATE = 2'd1;
    localparam logic [1:0] TAG_INVALID   = 2'd2;

    // statistic selectors
    localparam logic [3:0] STAT_PRIMARY   = 4'd0;
    localparam logic [3:0] STAT_ALTERNATE = 4'd1;
    localparam logic [3:0] STAT_INVALID   = 4'd2;
    localparam logic [3:0] STAT_STARVED   = 4'd3;
    localparam logic [3:0] STAT_REUSE     = 4'd4;
    localparam logic [3:0] STAT_MAX_AGE   = 4'd5;
    localparam logic [3:0] STAT_HIST0     = 4'd6;
    localparam logic [3:0] STAT_HIST1     = 4'd7;
    localparam logic [3:0] STAT_HIST2     = 4'd8;
    localparam logic [3:0] STAT_HIST3     = 4'd9;

    // histogram bin upper limits
    localparam t_cnt BIN0_LIMIT = t_cnt'(1);
    localparam t_cnt BIN1_LIMIT = t_cnt'(3);
    localparam t_cnt BIN2_LIMIT = t_cnt'(7);

    typedef struct packed {
        logic                       operation;
        logic [1:0]                 sample_tag;
        logic signed [PHASE_W-1:0]  phase_a_in;
        logic signed [PHASE_W-1:0]  phase_b_in;
        logic signed [PHASE_W-1:0]  phase_c_in;
        logic [3:0]                 stat_index;
    } t_in_item;

    typedef struct packed {
        logic                       ok;
        logic signed [PHASE_W-1:0]  phase_a_out;
        logic signed [PHASE_W-1:0]  phase_b_out;
        logic signed [PHASE_W-1:0]  phase_c_out;
        logic [RESULT_W-1:0]        age_now;
        logic [RESULT_W-1:0]        stat_value;
    } t_out_item;

    // events from the hold path to the statistics unit
    typedef struct packed {
        logic upd;
        logic primary;
        logic alternate;
        logic invalid;
        logic starved;
        logic reuse;
        t_cnt age;
    } t_stat_evt;

    function automatic t_cnt sat_inc(input t_cnt v);
        sat_inc = (v == '1) ? v : v + t_cnt'(1);
    endfunction

    function automatic logic [RESULT_W-1:0] to_result(input t_cnt v);
        to_result = RESULT_W'(v);
    endfunction

endpackage

>>> hdl/cshs_ifs.sv
interface cshs_in_if import cshs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface cshs_out_if import cshs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> hdl/cshs_stats.sv
module cshs_stats import cshs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_stat_evt i_evt,
    input  logic [3:0] i_stat_index,
    output t_cnt      o_stat_value
);

    t_cnt r_primary, r_alternate, r_invalid, r_starved, r_reuse, r_max_age;
    t_cnt n_primary, n_alternate, n_invalid, n_starved, n_reuse, n_max_age;
    t_cnt r_hist [HIST_BINS];
    t_cnt n_hist [HIST_BINS];
    t_bin w_bin;

    always_comb begin
        if (i_evt.age <= BIN0_LIMIT) begin
            w_bin = t_bin'(0);
        end else if (i_evt.age <= BIN1_LIMIT) begin
            w_bin = t_bin'(1);
        end else if (i_evt.age <= BIN2_LIMIT) begin
            w_bin = t_bin'(2);
        end else begin
            w_bin = t_bin'(3);
        end
    end

    always_comb begin
        n_primary   = (i_evt.upd && i_evt.primary)   ? sat_inc(r_primary)   : r_primary;
        n_alternate = (i_evt.upd && i_evt.alternate) ? sat_inc(r_alternate) : r_alternate;
        n_invalid   = (i_evt.upd && i_evt.invalid)   ? sat_inc(r_invalid)   : r_invalid;
        n_starved   = (i_evt.upd && i_evt.starved)   ? sat_inc(r_starved)   : r_starved;
        n_reuse     = (i_evt.upd && i_evt.reuse)     ? sat_inc(r_reuse)     : r_reuse;
        n_max_age   = (i_evt.upd && i_evt.reuse && (i_evt.age > r_max_age)) ?
                      i_evt.age : r_max_age;
        for (int i = 0; i < HIST_BINS; i++) begin
            n_hist[i] = (i_evt.upd && i_evt.reuse && (w_bin == t_bin'(i))) ?
                        sat_inc(r_hist[i]) : r_hist[i];
        end
    end

    // selection reads the values after this item's update
    always_comb begin
        case (i_stat_index)
            STAT_PRIMARY:   o_stat_value = n_primary;
            STAT_ALTERNATE: o_stat_value = n_alternate;
            STAT_INVALID:   o_stat_value = n_invalid;
            STAT_STARVED:   o_stat_value = n_starved;
            STAT_REUSE:     o_stat_value = n_reuse;
            STAT_MAX_AGE:   o_stat_value = n_max_age;
            STAT_HIST0:     o_stat_value = n_hist[0];
            STAT_HIST1:     o_stat_value = n_hist[1];
            STAT_HIST2:     o_stat_value = n_hist[2];
            STAT_HIST3:     o_stat_value = n_hist[3];
            default:        o_stat_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primary   <= '0;
            r_alternate <= '0;
            r_invalid   <= '0;
            r_starved   <= '0;
            r_reuse     <= '0;
            r_max_age   <= '0;
            for (int i = 0; i < HIST_BINS; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_primary   <= n_primary;
            r_alternate <= n_alternate;
            r_invalid   <= n_invalid;
            r_starved   <= n_starved;
            r_reuse     <= n_reuse;
            r_max_age   <= n_max_age;
            for (int i = 0; i < HIST_BINS; i++) begin
                r_hist[i] <= n_hist[i];
            end
        end
    end

endmodule

>>> hdl/current_sample_hold_with_stats.sv
// channel   dir  modport             payload
// i_smp     in   cshs_in_if.sink     operation, tag, three phase currents, stat select
// o_res     out  cshs_out_if.source  ok, three phase currents, age, selected statistic
//
// one item per clock sustained while o_res.ready is high; an item goes from input
// transfer via the input register, then the result register after the hold update
// synchronous active-low reset clears the hold, the age, all counters and both
// valid flags
// a stalled result holds in the result register while one more item waits in
// the input register; i_smp.ready drops only when both are full
module current_sample_hold_with_stats import cshs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cshs_in_if.sink           i_smp,
    cshs_out_if.source        o_res
);

    // input register
    logic      r_s1_valid;
    t_in_item  r_s1_item;

    // result register
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    // hold state
    logic signed [PHASE_W-1:0] r_held_a, r_held_b, r_held_c;
    logic signed [PHASE_W-1:0] n_held_a, n_held_b, n_held_c;
    logic r_have_held, n_have_held;
    t_cnt r_age, n_age;

    logic      w_s2_free;
    logic      w_s1_go;
    t_stat_evt w_evt;
    t_cnt      w_stat;
    logic      w_tag_valid;

    // result register empties or drains this cycle
    assign w_s2_free   = !r_out_valid || o_res.ready;
    assign w_s1_go     = r_s1_valid && w_s2_free;
    assign i_smp.ready = !r_s1_valid || w_s2_free;

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_item;

    assign w_tag_valid = (r_s1_item.sample_tag == TAG_PRIMARY) ||
                         (r_s1_item.sample_tag == TAG_ALTERNATE);

    // hold, age and event decode for the item in the input register
    always_comb begin
        n_held_a    = r_held_a;
        n_held_b    = r_held_b;
        n_held_c    = r_held_c;
        n_have_held = r_have_held;
        n_age       = r_age;

        w_evt           = '0;
        w_evt.upd       = w_s1_go;
        w_evt.age       = sat_inc(r_age);

        n_out_item             = '0;
        n_out_item.phase_a_out = '0;

        if (r_s1_item.operation == OP_RESTART) begin
            // restart drops the hold and the age, counters keep going
            n_held_a    = '0;
            n_held_b    = '0;
            n_held_c    = '0;
            n_have_held = 1'b0;
            n_age       = '0;
        end else if (w_tag_valid) begin
            // fresh sample passes through and becomes the substitute
            w_evt.primary          = (r_s1_item.sample_tag == TAG_PRIMARY);
            w_evt.alternate        = (r_s1_item.sample_tag == TAG_ALTERNATE);
            n_held_a               = r_s1_item.phase_a_in;
            n_held_b               = r_s1_item.phase_b_in;
            n_held_c               = r_s1_item.phase_c_in;
            n_have_held            = 1'b1;
            n_age                  = '0;
            n_out_item.ok          = 1'b1;
            n_out_item.phase_a_out = r_s1_item.phase_a_in;
            n_out_item.phase_b_out = r_s1_item.phase_b_in;
            n_out_item.phase_c_out = r_s1_item.phase_c_in;
        end else begin
            // invalid or unknown tag
            w_evt.invalid = 1'b1;
            if (!r_have_held) begin
                // nothing to substitute yet: refused
                w_evt.starved = 1'b1;
            end else begin
                w_evt.reuse            = 1'b1;
                n_age                  = w_evt.age;
                n_out_item.ok          = 1'b1;
                n_out_item.phase_a_out = r_held_a;
                n_out_item.phase_b_out = r_held_b;
                n_out_item.phase_c_out = r_held_c;
            end
        end

        n_out_item.age_now    = to_result(n_age);
        n_out_item.stat_value = to_result(w_stat);
    end

    cshs_stats u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (w_evt),
        .i_stat_index (r_s1_item.stat_index),
        .o_stat_value (w_stat)
    );

    // control and hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held_a    <= '0;
            r_held_b    <= '0;
            r_held_c    <= '0;
            r_have_held <= 1'b0;
            r_age       <= '0;
        end else begin
            if (i_smp.ready) begin
                r_s1_valid <= i_smp.valid;
            end
            if (w_s2_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_s1_go) begin
                r_held_a    <= n_held_a;
                r_held_b    <= n_held_b;
                r_held_c    <= n_held_c;
                r_have_held <= n_have_held;
                r_age       <= n_age;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_s1_item <= i_smp.data;
        end
        if (w_s1_go) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

>>> hdl/cshs_checker.sv
module cshs_checker import cshs_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_res_valid,
    input logic      i_res_ready,
    input t_out_item i_res_data
);

    // result channel is empty right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // a stalled result keeps valid and payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_data)))
        else $error("stalled result changed");

    // refused or restart result carries zero currents
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_data.ok) |->
        (i_res_data.phase_a_out == '0 && i_res_data.phase_b_out == '0 &&
         i_res_data.phase_c_out == '0))
        else $error("refused result with nonzero currents");

    // a nonzero age only exists while a substitute is held
    a_age_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_data.age_now != '0) |-> i_res_data.ok)
        else $error("nonzero age on refused result");

endmodule

bind current_sample_hold_with_stats cshs_checker u_cshs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

>>> tb/current_sample_hold_with_stats_tb.sv
`timescale 1ns / 100ps

module current_sample_hold_with_stats_tb import cshs_pkg::*; ();

    // tag value with no name in the package, handled as invalid
    localparam logic [1:0] TAG_UNKNOWN = 2'd3;

    // selector codes with no statistic behind them, read as zero
    localparam logic [3:0] STAT_SPARE_LO = 4'd14;
    localparam logic [3:0] STAT_SPARE_HI = 4'd15;

    localparam logic [PHASE_W-1:0] PH_MAX = 16'h7FFF;
    localparam logic [PHASE_W-1:0] PH_MIN = 16'h8000;
    localparam logic [PHASE_W-1:0] PH_ONES = 16'hFFFF;
    localparam logic [PHASE_W-1:0] PH_ONE = 16'h0001;

    localparam int IDLE_PCT     = 26;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cshs_in_if  smp_if ();
    cshs_out_if res_if ();

    current_sample_hold_with_stats u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of the hold stage and its statistics
    logic signed [PHASE_W-1:0] hold_a, hold_b, hold_c;
    logic                      hold_live;
    t_cnt                      age_q, peak_age;
    t_cnt                      n_primary, n_alternate, n_invalid, n_starved, n_reuse;
    t_cnt                      age_bins [HIST_BINS];

    t_out_item expected_q [$];
    t_out_item want;
    bit        gaps_on;
    int        mismatches  = 0;
    int        samples_sent = 0;
    int        idle_cycles = 0;

    function automatic t_cnt bump(input t_cnt v);
        return (v == {COUNTER_WIDTH{1'b1}}) ? v : v + t_cnt'(1);
    endfunction

    function automatic t_cnt stat_pick(input logic [3:0] sel);
        case (sel)
            STAT_PRIMARY:   return n_primary;
            STAT_ALTERNATE: return n_alternate;
            STAT_INVALID:   return n_invalid;
            STAT_STARVED:   return n_starved;
            STAT_REUSE:     return n_reuse;
            STAT_MAX_AGE:   return peak_age;
            STAT_HIST0:     return age_bins[0];
            STAT_HIST1:     return age_bins[1];
            STAT_HIST2:     return age_bins[2];
            STAT_HIST3:     return age_bins[3];
            default:        return '0;
        endcase
    endfunction

    // advances the shadow state by one sample and returns the result it yields
    function automatic t_out_item predict_hold(input t_in_item it);
        t_out_item r;
        t_bin      bin;
        r = '0;
        if (it.operation == OP_RESTART) begin
            hold_a    = '0;
            hold_b    = '0;
            hold_c    = '0;
            hold_live = 1'b0;
            age_q     = '0;
        end else if (it.sample_tag == TAG_PRIMARY || it.sample_tag == TAG_ALTERNATE) begin
            if (it.sample_tag == TAG_PRIMARY) n_primary = bump(n_primary);
            else n_alternate = bump(n_alternate);
            hold_a        = it.phase_a_in;
            hold_b        = it.phase_b_in;
            hold_c        = it.phase_c_in;
            hold_live     = 1'b1;
            age_q         = '0;
            r.ok          = 1'b1;
            r.phase_a_out = it.phase_a_in;
            r.phase_b_out = it.phase_b_in;
            r.phase_c_out = it.phase_c_in;
        end else begin
            n_invalid = bump(n_invalid);
            if (!hold_live) begin
                n_starved = bump(n_starved);
            end else begin
                // age moves first, then feeds the peak and the histogram
                age_q   = bump(age_q);
                n_reuse = bump(n_reuse);
                if (age_q > peak_age) peak_age = age_q;
                if (age_q <= BIN0_LIMIT) bin = t_bin'(0);
                else if (age_q <= BIN1_LIMIT) bin = t_bin'(1);
                else if (age_q <= BIN2_LIMIT) bin = t_bin'(2);
                else bin = t_bin'(3);
                age_bins[bin] = bump(age_bins[bin]);
                r.ok          = 1'b1;
                r.phase_a_out = hold_a;
                r.phase_b_out = hold_b;
                r.phase_c_out = hold_c;
            end
        end
        r.age_now    = RESULT_W'(age_q);
        r.stat_value = RESULT_W'(stat_pick(it.stat_index));
        return r;
    endfunction

    function automatic t_in_item make_item(input logic op, input logic [1:0] tag,
                                           input logic [PHASE_W-1:0] a,
                                           input logic [PHASE_W-1:0] b,
                                           input logic [PHASE_W-1:0] c,
                                           input logic [3:0] sel);
        t_in_item it;
        it.operation    = op;
        it.sample_tag   = tag;
        it.phase_a_in   = a;
        it.phase_b_in   = b;
        it.phase_c_in   = c;
        it.stat_index   = sel;
        return it;
    endfunction

    function automatic logic [PHASE_W-1:0] rand_phase();
        return PHASE_W'($urandom);
    endfunction

    // one sample transfer, with an optional idle gap in front of it
    task automatic send_sample(input t_in_item it);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.data  <= it;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        expected_q.push_back(predict_hold(it));
        samples_sent++;
    endtask

    // nothing held yet: restart, invalid and unknown tags are all refused
    task automatic test_empty_hold();
        send_sample(make_item(OP_RESTART, TAG_PRIMARY, PH_ONES, PH_ONES, PH_ONES,
                              STAT_PRIMARY));
        send_sample(make_item(OP_PROCESS, TAG_INVALID, PH_MAX, PH_MIN, PH_ONE,
                              STAT_STARVED));
        send_sample(make_item(OP_PROCESS, TAG_UNKNOWN, PH_ONES, PH_ONES, PH_ONES,
                              STAT_INVALID));
    endtask

    // valid samples pass straight through at the range limits
    task automatic test_pass_through();
        send_sample(make_item(OP_PROCESS, TAG_PRIMARY, PH_MAX, PH_MIN, '0, STAT_PRIMARY));
        send_sample(make_item(OP_PROCESS, TAG_ALTERNATE, PH_ONES, PH_ONE, PH_MIN,
                              STAT_ALTERNATE));
    endtask

    // ten invalid samples in a row walk the age through every histogram bin;
    // the selector sweeps the reuse count up into the unused codes
    task automatic test_stale_run();
        for (int k = 0; k < 10; k++) begin
            send_sample(make_item(OP_PROCESS, (k % 2) ? TAG_UNKNOWN : TAG_INVALID,
                                  rand_phase(), rand_phase(), rand_phase(),
                                  STAT_REUSE + 4'(k)));
        end
        send_sample(make_item(OP_PROCESS, TAG_PRIMARY, PH_MIN, PH_MAX, PH_ONES,
                              STAT_SPARE_LO));
        send_sample(make_item(OP_PROCESS, TAG_INVALID, '0, '0, '0, STAT_SPARE_HI));
    endtask

    // restart drops the hold and the age but leaves every counter alone
    task automatic test_restart_mid_run();
        send_sample(make_item(OP_RESTART, TAG_ALTERNATE, PH_MAX, PH_MAX, PH_MAX,
                              STAT_MAX_AGE));
        send_sample(make_item(OP_PROCESS, TAG_INVALID, PH_ONE, PH_ONE, PH_ONE, STAT_HIST3));
        send_sample(make_item(OP_PROCESS, TAG_ALTERNATE, PH_ONE, PH_MIN, PH_MAX, STAT_HIST0));
        send_sample(make_item(OP_PROCESS, TAG_INVALID, '0, '0, '0, STAT_HIST0));
    endtask

    // mostly a valid sample followed by a run of dropouts, plus restarts
    // and fully random items as noise
    task automatic run_mix(input int count);
        int stop;
        int run;
        stop = samples_sent + count;
        while (samples_sent < stop) begin
            if ($urandom_range(99) < 70) begin
                send_sample(make_item(OP_PROCESS,
                                      $urandom_range(1) ? TAG_ALTERNATE : TAG_PRIMARY,
                                      rand_phase(), rand_phase(), rand_phase(),
                                      4'($urandom_range(15))));
                run = $urandom_range(12);
                repeat (run) begin
                    send_sample(make_item(OP_PROCESS,
                                          $urandom_range(3) ? TAG_INVALID : TAG_UNKNOWN,
                                          rand_phase(), rand_phase(), rand_phase(),
                                          4'($urandom_range(15))));
                end
            end else if ($urandom_range(2) == 0) begin
                send_sample(make_item(OP_RESTART, 2'($urandom), rand_phase(),
                                      rand_phase(), rand_phase(), 4'($urandom_range(15))));
            end else begin
                send_sample(make_item($urandom_range(9) == 0 ? OP_RESTART : OP_PROCESS,
                                      2'($urandom), rand_phase(), rand_phase(),
                                      rand_phase(), 4'($urandom_range(15))));
            end
        end
    endtask

    task automatic test_random_traffic();
        gaps_on = 1'b1;
        run_mix(1400);
    endtask

    // long stretch with neither side idling
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        run_mix(300);
        gaps_on = 1'b1;
    endtask

    // result side: random stalls, checks every transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: ok=%0b a=%h b=%h c=%h age=%h stat=%h",
                             res_if.data.ok, res_if.data.phase_a_out,
                             res_if.data.phase_b_out, res_if.data.phase_c_out,
                             res_if.data.age_now, res_if.data.stat_value);
            end else begin
                want = expected_q.pop_front();
                if (res_if.data.ok !== want.ok
                        || res_if.data.phase_a_out !== want.phase_a_out
                        || res_if.data.phase_b_out !== want.phase_b_out
                        || res_if.data.phase_c_out !== want.phase_c_out
                        || res_if.data.age_now !== want.age_now
                        || res_if.data.stat_value !== want.stat_value) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch at %0t: expected ok=%0b a=%h b=%h c=%h age=%h stat=%h",
                                 $realtime, want.ok, want.phase_a_out, want.phase_b_out,
                                 want.phase_c_out, want.age_now, want.stat_value);
                        $display("               actual   ok=%0b a=%h b=%h c=%h age=%h stat=%h",
                                 res_if.data.ok, res_if.data.phase_a_out,
                                 res_if.data.phase_b_out, res_if.data.phase_c_out,
                                 res_if.data.age_now, res_if.data.stat_value);
                    end
                end
            end
        end
        res_if.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        smp_if.valid = 1'b0;
        smp_if.data  = '0;
        res_if.ready = 1'b0;
        hold_a       = '0;
        hold_b       = '0;
        hold_c       = '0;
        hold_live    = 1'b0;
        age_q        = '0;
        peak_age     = '0;
        n_primary    = '0;
        n_alternate  = '0;
        n_invalid    = '0;
        n_starved    = '0;
        n_reuse      = '0;
        foreach (age_bins[k]) age_bins[k] = '0;
        gaps_on      = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_hold();
        test_pass_through();
        test_stale_run();
        test_restart_mid_run();
        test_random_traffic();
        test_back_to_back();

        smp_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
